>>> src/input_window_recorder_assert.svh
// Assertion macros used by the checker module of the input window recorder.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef INPUT_WINDOW_RECORDER_ASSERT_SVH
`define INPUT_WINDOW_RECORDER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define IWR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("input window recorder assertion failed");

// The consequent holds in the cycle after the antecedent.
`define IWR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("input window recorder assertion failed");

`endif

>>> src/iwr_pkg.sv
// Shared types and constants of the input window recorder.
// Used by the controller, the window memory, the top level and the checker.
package iwr_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_RECORD = 2'd1,
    OP_QFRAME = 2'd2,
    OP_QRANGE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERWRITE = 2'd1,
    ERR_FULL      = 2'd2
  } err_e;

  localparam int unsigned FrameW = 32;
  localparam int unsigned BitsW  = 16;
  localparam logic [FrameW-1:0] FrameTop = '1;

  typedef struct packed {
    logic [FrameW-1:0] first;
    logic [FrameW-1:0] last;
    logic [BitsW-1:0]  bits;
  } win_t;

  typedef struct packed {
    logic             ok;
    err_e             error_code;
    logic [BitsW-1:0] frame_mask;
    logic             found;
  } res_t;

endpackage

>>> src/iwr_mem.sv
// Window table memory: one write port and one read port with registered read data.
// Depends on iwr_pkg for the window entry type.
module iwr_mem #(
  parameter int unsigned MAX_WINDOWS = 64,
  localparam int unsigned IdxW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  iwr_pkg::win_t     wdata_i,
  input  logic              re_i,
  input  logic [IdxW-1:0]   raddr_i,
  output iwr_pkg::win_t     rdata_o
);

  iwr_pkg::win_t mem_q [MAX_WINDOWS];
  iwr_pkg::win_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/iwr_ctrl.sv
// Sequencer of the input window recorder: record read-modify-write and query scans.
// Depends on iwr_pkg; drives the window memory and hands one result to the top level.
module iwr_ctrl #(
  parameter int unsigned MAX_WINDOWS = 64,
  localparam int unsigned IdxW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
  localparam int unsigned CntW = $clog2(MAX_WINDOWS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [iwr_pkg::FrameW-1:0]  frame_i,
  input  logic [iwr_pkg::FrameW-1:0]  range_end_i,
  input  logic [iwr_pkg::BitsW-1:0]   mask_bits_i,
  output logic                        mem_we_o,
  output logic [IdxW-1:0]             mem_waddr_o,
  output iwr_pkg::win_t               mem_wdata_o,
  output logic                        mem_re_o,
  output logic [IdxW-1:0]             mem_raddr_o,
  input  iwr_pkg::win_t               mem_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_stall_i,
  output iwr_pkg::res_t               res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REC  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [IdxW-1:0]              idx_q, idx_d;
  iwr_pkg::op_e                 op_q, op_d;
  logic [iwr_pkg::FrameW-1:0]   frame_q, frame_d;
  logic [iwr_pkg::FrameW-1:0]   rend_q, rend_d;
  logic [iwr_pkg::BitsW-1:0]    mask_q, mask_d;
  iwr_pkg::res_t                res_q, res_d;

  logic [CntW-1:0]              count_m1;
  logic [IdxW-1:0]              last_idx;
  logic                         full;
  logic                         in_win;
  logic                         single;
  logic                         covers;
  logic                         overlaps;
  logic                         holds_all;

  assign count_m1  = count_q - CntW'(1);
  assign last_idx  = count_m1[IdxW-1:0];
  assign full      = (count_q == CntW'(MAX_WINDOWS));
  assign in_win    = (frame_q >= mem_rdata_i.first) && (frame_q <= mem_rdata_i.last);
  assign single    = (mem_rdata_i.first == frame_q) && (mem_rdata_i.last == frame_q);
  assign covers    = in_win;
  assign overlaps  = !((mem_rdata_i.last < frame_q) || (mem_rdata_i.first > rend_q));
  assign holds_all = ((mem_rdata_i.bits & mask_q) == mask_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    op_d        = op_q;
    frame_d     = frame_q;
    rend_d      = rend_q;
    mask_d      = mask_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = iwr_pkg::op_e'(opcode_i);
          frame_d = frame_i;
          rend_d  = range_end_i;
          mask_d  = mask_bits_i;
          res_d   = '{ok: 1'b1, error_code: iwr_pkg::ERR_NONE, frame_mask: '0, found: 1'b0};
          state_d = S_FIN;
          unique case (iwr_pkg::op_e'(opcode_i))
            iwr_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            iwr_pkg::OP_RECORD: begin
              if (mask_bits_i != '0) begin
                if (count_q == '0) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = '0;
                  mem_wdata_o = '{first: frame_i, last: frame_i, bits: mask_bits_i};
                  count_d     = CntW'(1);
                end else begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = last_idx;
                  state_d     = S_REC;
                end
              end
            end
            iwr_pkg::OP_QFRAME: begin
              if (count_q != '0) begin
                mem_re_o = 1'b1;
                idx_d    = '0;
                state_d  = S_SCAN;
              end
            end
            iwr_pkg::OP_QRANGE: begin
              if ((count_q != '0) && (range_end_i >= frame_i)) begin
                mem_re_o = 1'b1;
                idx_d    = '0;
                state_d  = S_SCAN;
              end
            end
          endcase
        end
      end
      S_REC: begin
        state_d = S_FIN;
        priority if (in_win) begin
          if (single) begin
            mem_we_o         = 1'b1;
            mem_waddr_o      = last_idx;
            mem_wdata_o.bits = mask_q;
          end else if (!((mem_rdata_i.bits == mask_q) && (mem_rdata_i.last == frame_q))) begin
            res_d.ok         = 1'b0;
            res_d.error_code = iwr_pkg::ERR_OVERWRITE;
          end
        end else if ((mem_rdata_i.bits == mask_q) && (mem_rdata_i.last != iwr_pkg::FrameTop)
                     && ((mem_rdata_i.last + iwr_pkg::FrameW'(1)) == frame_q)) begin
          mem_we_o         = 1'b1;
          mem_waddr_o      = last_idx;
          mem_wdata_o.last = frame_q;
        end else if (full) begin
          res_d.ok         = 1'b0;
          res_d.error_code = iwr_pkg::ERR_FULL;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = count_q[IdxW-1:0];
          mem_wdata_o = '{first: frame_q, last: frame_q, bits: mask_q};
          count_d     = count_q + CntW'(1);
        end
      end
      S_SCAN: begin
        if ((op_q == iwr_pkg::OP_QFRAME) && covers) begin
          res_d.frame_mask = res_q.frame_mask | mem_rdata_i.bits;
        end
        if ((op_q == iwr_pkg::OP_QRANGE) && overlaps && holds_all) begin
          res_d.found = 1'b1;
        end
        if (idx_q == last_idx) begin
          state_d = S_FIN;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + IdxW'(1);
          idx_d       = idx_q + IdxW'(1);
        end
      end
      S_FIN: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    op_q    <= op_d;
    frame_q <= frame_d;
    rend_q  <= rend_d;
    mask_q  <= mask_d;
    res_q   <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_FIN);
  assign res_o       = res_q;

endmodule

>>> src/input_window_recorder.sv
// Input window recorder: a table of frame windows with button masks.
// The input channel (in_valid_i, in_stall_o) takes one item with opcode_i, frame_i,
// range_end_i and mask_bits_i; the output channel (out_valid_o, out_stall_i) returns
// exactly one result item per input item with ok_o, error_code_o, frame_mask_o, found_o.
// One item is worked on at a time; in_stall_o is high from acceptance until the
// result has moved into the output register.
// Clear, a zero-mask record, a record into an empty table, a query on an empty table and
// a range query with a reversed range go straight to the result; any other record first
// reads the newest window, and any other query scans all stored windows in order.
// A query scans through the single read port of the window memory, which reads one
// stored window per cycle; a record is a read-modify-write of the newest window.
// The output register lets the next item be accepted while a result is held under
// out_stall_i; a further result then waits inside the controller.
// Reset empties the table; window contents are not cleared and need no clearing pass.
module input_window_recorder #(
  parameter int unsigned MAX_WINDOWS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [iwr_pkg::FrameW-1:0]  frame_i,
  input  logic [iwr_pkg::FrameW-1:0]  range_end_i,
  input  logic [iwr_pkg::BitsW-1:0]   mask_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [1:0]                  error_code_o,
  output logic [iwr_pkg::BitsW-1:0]   frame_mask_o,
  output logic                        found_o
);

  localparam int unsigned IdxW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  iwr_pkg::win_t     mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  iwr_pkg::win_t     mem_rdata;
  logic              res_valid;
  logic              res_stall;
  iwr_pkg::res_t     res;
  logic              out_valid_q, out_valid_d;
  iwr_pkg::res_t     out_q;

  iwr_ctrl #(
    .MAX_WINDOWS(MAX_WINDOWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .frame_i     (frame_i),
    .range_end_i (range_end_i),
    .mask_bits_i (mask_bits_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res)
  );

  iwr_mem #(
    .MAX_WINDOWS(MAX_WINDOWS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_stall = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && !res_stall) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_q.ok;
  assign error_code_o = 2'(out_q.error_code);
  assign frame_mask_o = out_q.frame_mask;
  assign found_o      = out_q.found;

endmodule

>>> src/iwr_chk.sv
// Port-level checker of the input window recorder, bound to the top level.
// Depends on iwr_pkg and on the assertion macros in input_window_recorder_assert.svh.
`include "input_window_recorder_assert.svh"

module iwr_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  opcode_i,
  input logic [iwr_pkg::FrameW-1:0]  frame_i,
  input logic [iwr_pkg::FrameW-1:0]  range_end_i,
  input logic [iwr_pkg::BitsW-1:0]   mask_bits_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        ok_o,
  input logic [1:0]                  error_code_o,
  input logic [iwr_pkg::BitsW-1:0]   frame_mask_o,
  input logic                        found_o
);

  logic                          no_err;
  logic                          no_data;
  logic                          out_held;
  logic [iwr_pkg::BitsW+3:0]     out_word;

  assign no_err   = (error_code_o == iwr_pkg::ERR_NONE);
  assign no_data  = (frame_mask_o == '0) && !found_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {ok_o, error_code_o, frame_mask_o, found_o};

  // An accepted item keeps the block busy at least until the next edge.
  `IWR_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `IWR_ASSERT_IMP(a_ok_matches_error, clk_i, rst_ni, out_valid_o, ok_o == no_err)

  // Only a query reports data, and a query never fails.
  `IWR_ASSERT_IMP(a_error_no_data, clk_i, rst_ni, out_valid_o && !ok_o, no_data)

  `IWR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_word))

endmodule

bind input_window_recorder iwr_chk u_iwr_chk (.*);
